// ===== design/bglr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Background line renderer package
// Shared constants, codes, structs and small helper functions.
// ----------------------------------------------------------------------------
package bglr_pkg;

	localparam int EXT_PALETTE_SLOTS = 4;
	localparam int SCREEN_SPAN       = 512;
	localparam int EXT_DEPTH         = EXT_PALETTE_SLOTS * 4096;
	localparam int EXT_AW            = $clog2(EXT_DEPTH);
	localparam int STD_DEPTH         = 256;

	typedef enum logic [2:0] {
		OP_PAL_WR    = 3'd0,
		OP_EXT_WR    = 3'd1,
		OP_MAP_ADDR  = 3'd2,
		OP_CHAR_ADDR = 3'd3,
		OP_RENDER    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		REG_CHAR_BASE  = 3'd0,
		REG_MAP_BASE   = 3'd1,
		REG_SCREEN     = 3'd2,
		REG_COLOUR_256 = 3'd3,
		REG_EXT_EN     = 3'd4,
		REG_EXT_SLOT   = 3'd5,
		REG_SCROLL_X   = 3'd6,
		REG_SCROLL_Y   = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [18:0] char_base;
		logic [18:0] map_base;
		logic [1:0]  bg_layout;
		logic        colour_256;
		logic        ext_enable;
		logic [1:0]  ext_slot;
		logic [8:0]  scroll_x;
		logic [8:0]  scroll_y;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic              std_we;
		logic              ext_we;
		logic [7:0]        std_addr;
		logic [EXT_AW-1:0] ext_addr;
		logic [15:0]       wdata;
	} pal_req_t;

	typedef struct packed {
		logic        valid;
		logic        is_pix;
		logic        use_ext;
		logic        transparent;
		logic        last;
		logic [19:0] address;
		logic [7:0]  pixel_x;
	} res_meta_t;

	// fold a background coordinate back into the screen span
	function automatic logic [8:0] wrap_span(input logic [9:0] v);
		logic [9:0] t;
		t = v;
		for (int k = 0; k < 3; k++) begin
			if (t >= 10'(SCREEN_SPAN))
				t = t - 10'(SCREEN_SPAN);
		end
		return t[8:0];
	endfunction

	// wrap an extended palette slot onto the slots that exist
	function automatic logic [1:0] slot_wrap(input logic [1:0] s);
		logic [2:0] t;
		t = {1'b0, s};
		for (int k = 0; k < 3; k++) begin
			if (t >= 3'(EXT_PALETTE_SLOTS))
				t = t - 3'(EXT_PALETTE_SLOTS);
		end
		return t[1:0];
	endfunction

endpackage
`default_nettype wire

// ===== design/bglr_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one operation transaction.
// ----------------------------------------------------------------------------
interface bglr_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  operation;
	logic [7:0]  line;
	logic [4:0]  tile_column;
	logic [15:0] map_entry;
	logic [63:0] row_pixels;
	logic [7:0]  palette_entry;
	logic [5:0]  palette_bank;
	logic [15:0] palette_colour;

	modport source (output valid, operation, line, tile_column, map_entry, row_pixels,
		palette_entry, palette_bank, palette_colour, input ready);
	modport sink (input valid, operation, line, tile_column, map_entry, row_pixels,
		palette_entry, palette_bank, palette_colour, output ready);
endinterface
`default_nettype wire

// ===== design/bglr_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one address or pixel transaction.
// ----------------------------------------------------------------------------
interface bglr_rsp_if;
	logic        valid;
	logic        ready;
	logic [19:0] address;
	logic [7:0]  pixel_x;
	logic [15:0] colour;
	logic        transparent;
	logic        last;

	modport source (output valid, address, pixel_x, colour, transparent, last, input ready);
	modport sink (input valid, address, pixel_x, colour, transparent, last, output ready);
endinterface
`default_nettype wire

// ===== design/tiled_background_line_renderer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Tiled background line renderer
// Palette loads, map and character row offsets, and 8-pixel tile expansion.
// ----------------------------------------------------------------------------
// An accepted transaction passes the input, sequencer, palette read and output
// registers. One result per cycle unless rsp.ready stalls; a render holds the
// sequencer for its eight pixels, every other transaction for a single step.
// Reset clears configuration registers and pipeline valid bits; palette
// contents are undefined until written.
module tiled_background_line_renderer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [18:0] cfg_data,
	bglr_req_if.sink    req,
	bglr_rsp_if.source  rsp
);
	import bglr_pkg::*;

	cfg_t      cfg_q;
	logic      adv;
	pal_req_t  pal_req;
	res_meta_t meta;
	res_meta_t meta_s3;
	logic [15:0] std_rd_s3;
	logic [15:0] ext_rd_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHAR_BASE:  cfg_q.char_base   <= cfg_data;
				REG_MAP_BASE:   cfg_q.map_base    <= cfg_data;
				REG_SCREEN:     cfg_q.bg_layout   <= cfg_data[1:0];
				REG_COLOUR_256: cfg_q.colour_256  <= cfg_data[0];
				REG_EXT_EN:     cfg_q.ext_enable  <= cfg_data[0];
				REG_EXT_SLOT:   cfg_q.ext_slot    <= cfg_data[1:0];
				REG_SCROLL_X:   cfg_q.scroll_x    <= cfg_data[8:0];
				REG_SCROLL_Y:   cfg_q.scroll_y    <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	bglr_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.cfg     (cfg_q),
		.adv     (adv),
		.pal_req (pal_req),
		.meta    (meta)
	);

	bglr_pal u_pal (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.pal_req   (pal_req),
		.meta      (meta),
		.meta_s3   (meta_s3),
		.std_rd_s3 (std_rd_s3),
		.ext_rd_s3 (ext_rd_s3)
	);

	bglr_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.meta_s3   (meta_s3),
		.std_rd_s3 (std_rd_s3),
		.ext_rd_s3 (ext_rd_s3),
		.adv       (adv),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== design/bglr_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Operation sequencer
// Input register, then a stage that steps render items through their eight pixels and
// works out palette accesses and VRAM offsets.
// ----------------------------------------------------------------------------
module bglr_seq (
	input  logic               clk,
	input  logic               arst_n,
	bglr_req_if.sink           req,
	input  bglr_pkg::cfg_t     cfg,
	input  logic               adv,
	output bglr_pkg::pal_req_t pal_req,
	output bglr_pkg::res_meta_t meta
);
	import bglr_pkg::*;

	logic        valid_s1;
	logic [2:0]  op_s1;
	logic [7:0]  line_s1;
	logic [4:0]  col_s1;
	logic [15:0] entry_s1;
	logic [63:0] row_s1;
	logic [7:0]  pe_s1;
	logic [5:0]  bank_s1;
	logic [15:0] pcol_s1;

	logic        valid_s2;
	logic [2:0]  op_s2;
	logic [7:0]  line_s2;
	logic [4:0]  col_s2;
	logic [15:0] entry_s2;
	logic [63:0] row_s2;
	logic [7:0]  pe_s2;
	logic [5:0]  bank_s2;
	logic [15:0] pcol_s2;
	logic [2:0]  cnt_s2;

	logic        done;
	logic        load_s2;

	logic [8:0]  y;
	logic [8:0]  x;
	logic [2:0]  r;
	logic [19:0] map_addr;
	logic [19:0] char_addr;
	logic [19:0] y_step;
	logic [19:0] x_step;
	logic [2:0]  j;
	logic [7:0]  idx8;
	logic [3:0]  idx4;
	logic [7:0]  idx;
	logic [1:0]  slot;
	logic [7:0]  px;
	logic        use_ext;

	assign done    = valid_s2 && ((op_s2 != OP_RENDER) || (cnt_s2 == 3'd7));
	assign load_s2 = adv && (!valid_s2 || done);
	assign req.ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1    <= req.operation;
			line_s1  <= req.line;
			col_s1   <= req.tile_column;
			entry_s1 <= req.map_entry;
			row_s1   <= req.row_pixels;
			pe_s1    <= req.palette_entry;
			bank_s1  <= req.palette_bank;
			pcol_s1  <= req.palette_colour;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			cnt_s2   <= 3'd0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
			cnt_s2   <= 3'd0;
		end else if (adv && valid_s2) begin
			cnt_s2 <= cnt_s2 + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			op_s2    <= op_s1;
			line_s2  <= line_s1;
			col_s2   <= col_s1;
			entry_s2 <= entry_s1;
			row_s2   <= row_s1;
			pe_s2    <= pe_s1;
			bank_s2  <= bank_s1;
			pcol_s2  <= pcol_s1;
		end
	end

	// background coordinates and VRAM offsets
	assign y = wrap_span(10'(line_s2) + 10'(cfg.scroll_y));
	assign x = wrap_span({2'b00, col_s2, 3'b000} + 10'(cfg.scroll_x));
	assign y_step = (y[8] && cfg.bg_layout[1]) ?
		(cfg.bg_layout[0] ? 20'h01000 : 20'h00800) : 20'h00000;
	assign x_step = (x[8] && cfg.bg_layout[0]) ? 20'h00800 : 20'h00000;
	assign map_addr = 20'(cfg.map_base) + {9'b0, y[7:3], 6'b0} + {14'b0, x[7:3], 1'b0}
		+ y_step + x_step;
	assign r = entry_s2[11] ? ~y[2:0] : y[2:0];
	assign char_addr = cfg.colour_256 ?
		(20'(cfg.char_base) + {4'b0, entry_s2[9:0], 6'b0} + {14'b0, r, 3'b0}) :
		(20'(cfg.char_base) + {5'b0, entry_s2[9:0], 5'b0} + {15'b0, r, 2'b0});

	// pixel beat
	assign j       = cnt_s2;
	assign idx8    = row_s2[{j, 3'b000} +: 8];
	assign idx4    = row_s2[{j, 2'b00} +: 4];
	assign idx     = cfg.colour_256 ? idx8 : {4'b0000, idx4};
	assign slot    = slot_wrap(cfg.ext_slot);
	assign use_ext = cfg.colour_256 && cfg.ext_enable;
	assign px      = {col_s2, entry_s2[10] ? ~j : j};

	always_comb begin
		pal_req.en     = adv && valid_s2;
		pal_req.std_we = 1'b0;
		pal_req.ext_we = 1'b0;
		pal_req.std_addr = cfg.colour_256 ? idx8 : {entry_s2[15:12], idx4};
		pal_req.ext_addr = EXT_AW'({slot, entry_s2[15:12], idx8});
		pal_req.wdata  = pcol_s2;

		meta.valid       = 1'b0;
		meta.is_pix      = 1'b0;
		meta.use_ext     = 1'b0;
		meta.transparent = 1'b0;
		meta.last        = 1'b1;
		meta.address     = 20'd0;
		meta.pixel_x     = 8'd0;

		case (op_s2)
			OP_PAL_WR: begin
				pal_req.std_we   = 1'b1;
				pal_req.std_addr = pe_s2;
			end
			OP_EXT_WR: begin
				// drop writes to slots that do not exist
				pal_req.ext_we   = 3'({1'b0, bank_s2[5:4]}) < 3'(EXT_PALETTE_SLOTS);
				pal_req.ext_addr = EXT_AW'({bank_s2, pe_s2});
			end
			OP_MAP_ADDR: begin
				meta.valid   = valid_s2;
				meta.address = map_addr;
			end
			OP_CHAR_ADDR: begin
				meta.valid   = valid_s2;
				meta.address = char_addr;
			end
			OP_RENDER: begin
				meta.valid       = valid_s2;
				meta.is_pix      = 1'b1;
				meta.use_ext     = use_ext;
				meta.transparent = (idx == 8'd0);
				meta.last        = (j == 3'd7);
				meta.pixel_x     = px;
			end
			default: begin
			end
		endcase
	end

	a_cnt_render: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_s2 != 3'd0) |-> (valid_s2 && (op_s2 == OP_RENDER)))
		else $error("beat count set outside a render item");

	a_hold_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !adv) |=> (valid_s2 && $stable(cnt_s2)))
		else $error("sequencer moved during a stall");

	a_capture: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> valid_s1)
		else $error("accepted transaction not held in input stage");

endmodule
`default_nettype wire

// ===== design/bglr_pal.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Palette memories
// Standard and extended palette RAMs with registered read data.
// ----------------------------------------------------------------------------
module bglr_pal (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  bglr_pkg::pal_req_t  pal_req,
	input  bglr_pkg::res_meta_t meta,
	output bglr_pkg::res_meta_t meta_s3,
	output logic [15:0]         std_rd_s3,
	output logic [15:0]         ext_rd_s3
);
	import bglr_pkg::*;

	logic [15:0] std_mem [STD_DEPTH];
	logic [15:0] ext_mem [EXT_DEPTH];

	always_ff @(posedge clk) begin
		if (pal_req.en) begin
			if (pal_req.std_we)
				std_mem[pal_req.std_addr] <= pal_req.wdata;
			std_rd_s3 <= std_mem[pal_req.std_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pal_req.en) begin
			if (pal_req.ext_we)
				ext_mem[pal_req.ext_addr] <= pal_req.wdata;
			ext_rd_s3 <= ext_mem[pal_req.ext_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meta_s3 <= '0;
		end else if (adv) begin
			meta_s3 <= meta;
		end
	end

endmodule
`default_nettype wire

// ===== design/bglr_out.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Output stage
// Picks the palette colour, applies transparency and holds the result.
// ----------------------------------------------------------------------------
module bglr_out (
	input  logic                clk,
	input  logic                arst_n,
	input  bglr_pkg::res_meta_t meta_s3,
	input  logic [15:0]         std_rd_s3,
	input  logic [15:0]         ext_rd_s3,
	output logic                adv,
	bglr_rsp_if.source          rsp
);
	import bglr_pkg::*;

	logic        valid_s4;
	logic [19:0] address_s4;
	logic [7:0]  pixel_x_s4;
	logic [15:0] colour_s4;
	logic        transparent_s4;
	logic        last_s4;
	logic [15:0] colour;

	assign adv = !valid_s4 || rsp.ready;

	always_comb begin
		if (!meta_s3.is_pix || meta_s3.transparent)
			colour = 16'd0;
		else if (meta_s3.use_ext)
			colour = ext_rd_s3;
		else
			colour = std_rd_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= meta_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			address_s4     <= meta_s3.address;
			pixel_x_s4     <= meta_s3.pixel_x;
			colour_s4      <= colour;
			transparent_s4 <= meta_s3.transparent;
			last_s4        <= meta_s3.last;
		end
	end

	assign rsp.valid       = valid_s4;
	assign rsp.address     = address_s4;
	assign rsp.pixel_x     = pixel_x_s4;
	assign rsp.colour      = colour_s4;
	assign rsp.transparent = transparent_s4;
	assign rsp.last        = last_s4;

	a_transp_black: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && transparent_s4) |-> (colour_s4 == 16'd0))
		else $error("transparent pixel with nonzero colour");

	a_pix_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && !last_s4) |-> (address_s4 == 20'd0))
		else $error("pixel transaction carries an address");

	a_addr_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s4 && (address_s4 != 20'd0)) |-> (!transparent_s4 && last_s4))
		else $error("address transaction with pixel flags");

endmodule
`default_nettype wire
